// ===== rtl/uahg_pkg.sv =====
// shared types, constants and header word selection for the frame header generator
package uahg_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT = 2'd2;

  // frame kinds
  localparam logic FUNC_UDP = 1'b0;
  localparam logic FUNC_ARP = 1'b1;

  localparam logic [WORD_W-1:0] ETHTYPE_IPV4  = 16'h0800;
  localparam logic [WORD_W-1:0] ETHTYPE_ARP   = 16'h0806;
  localparam logic [WORD_W-1:0] ARP_HTYPE     = 16'h0001;
  localparam logic [WORD_W-1:0] ARP_HLEN_PLEN = 16'h0604;
  localparam logic [WORD_W-1:0] ARP_OP_REPLY  = 16'h0002;
  localparam logic [WORD_W-1:0] IP_VER_IHL    = 16'h4500;
  localparam logic [WORD_W-1:0] IP_TTL_PROTO  = 16'h4011;
  localparam logic [WORD_W-1:0] PAD_WORD0     = 16'h794d;
  localparam logic [WORD_W-1:0] PAD_WORD1     = 16'h6569;
  localparam logic [WORD_W-1:0] PAD_WORD2     = 16'h4950;
  localparam logic [WORD_W-1:0] IP_LEN_ADD    = 16'd34;
  localparam logic [WORD_W-1:0] UDP_LEN_ADD   = 16'd14;

  localparam logic [POS_W-1:0] UDP_LAST_POS = 5'd23;
  localparam logic [POS_W-1:0] ARP_LAST_POS = 5'd20;

  typedef struct packed {
    logic [MAC_W-1:0]  own_mac;
    logic [IP_W-1:0]   own_ip;
    logic [PORT_W-1:0] own_port;
  } own_cfg_t;

  typedef struct packed {
    logic              func;
    logic [MAC_W-1:0]  peer_mac;
    logic [IP_W-1:0]   peer_ip;
    logic [PORT_W-1:0] peer_port;
    logic [WORD_W-1:0] ip_len;
    logic [WORD_W-1:0] udp_len;
    logic [SUM_W-1:0]  csum_sum;
  } req_desc_t;

  function automatic logic is_last_pos(input logic func, input logic [POS_W-1:0] pos);
    is_last_pos = (func == FUNC_UDP) ? (pos == UDP_LAST_POS) : (pos == ARP_LAST_POS);
  endfunction

  function automatic logic [WORD_W-1:0] hdr_word_f(input req_desc_t d, input own_cfg_t c,
                                                   input logic [POS_W-1:0] pos);
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [WORD_W-1:0] csum;
    logic [WORD_W-1:0] w;
    // two folds are enough for a sum below 2^19
    fold1 = {1'b0, d.csum_sum[15:0]} + {14'd0, d.csum_sum[18:16]};
    fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    csum  = ~fold2[15:0];
    w     = '0;
    case (pos)
      5'd0: w = d.peer_mac[47:32];
      5'd1: w = d.peer_mac[31:16];
      5'd2: w = d.peer_mac[15:0];
      5'd3: w = c.own_mac[47:32];
      5'd4: w = c.own_mac[31:16];
      5'd5: w = c.own_mac[15:0];
      default: begin
        if (d.func == FUNC_UDP) begin
          case (pos)
            5'd6:  w = ETHTYPE_IPV4;
            5'd7:  w = IP_VER_IHL;
            5'd8:  w = d.ip_len;
            5'd11: w = IP_TTL_PROTO;
            5'd12: w = csum;
            5'd13: w = c.own_ip[31:16];
            5'd14: w = c.own_ip[15:0];
            5'd15: w = d.peer_ip[31:16];
            5'd16: w = d.peer_ip[15:0];
            5'd17: w = c.own_port;
            5'd18: w = d.peer_port;
            5'd19: w = d.udp_len;
            5'd21: w = PAD_WORD0;
            5'd22: w = PAD_WORD1;
            5'd23: w = PAD_WORD2;
            default: w = '0;
          endcase
        end else begin
          case (pos)
            5'd6:  w = ETHTYPE_ARP;
            5'd7:  w = ARP_HTYPE;
            5'd8:  w = ETHTYPE_IPV4;
            5'd9:  w = ARP_HLEN_PLEN;
            5'd10: w = ARP_OP_REPLY;
            5'd11: w = c.own_mac[47:32];
            5'd12: w = c.own_mac[31:16];
            5'd13: w = c.own_mac[15:0];
            5'd14: w = c.own_ip[31:16];
            5'd15: w = c.own_ip[15:0];
            5'd16: w = d.peer_mac[47:32];
            5'd17: w = d.peer_mac[31:16];
            5'd18: w = d.peer_mac[15:0];
            5'd19: w = d.peer_ip[31:16];
            5'd20: w = d.peer_ip[15:0];
            default: w = '0;
          endcase
        end
      end
    endcase
    hdr_word_f = w;
  endfunction

endpackage

// ===== rtl/uahg_if.sv =====
// request and header word channel interfaces
interface uahg_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [47:0] peer_mac;
  logic [31:0] peer_ip;
  logic [15:0] peer_port;
  logic [15:0] payload_len;

  modport source (output valid, func, peer_mac, peer_ip, peer_port, payload_len,
                  input ready);
  modport sink (input valid, func, peer_mac, peer_ip, peer_port, payload_len,
                output ready);
endinterface

interface uahg_hdr_if;
  logic        valid;
  logic        ready;
  logic [15:0] hdr_word;
  logic [4:0]  word_pos;
  logic        is_last;

  modport source (output valid, hdr_word, word_pos, is_last, input ready);
  modport sink (input valid, hdr_word, word_pos, is_last, output ready);
endinterface

// ===== rtl/udp_arp_frame_header_generator_unit.sv =====
// UDP/IPv4 and ARP reply frame header generator, top level
// Usage:
//   req_i carries one request per handshake: frame kind (0 UDP/IPv4, 1 ARP
//   reply), peer MAC, peer IP, peer port and payload length.
//   hdr_o carries the header as 16-bit words, high byte first, each with its
//   position and a last flag. A UDP request gives 24 words, an ARP reply 21.
//   own MAC, IP and port are set through the write port (index 0, 1, 2;
//   others ignored) by the user only while idle; the block does not enforce.
// Timing:
//   An accepted request is first written into the descriptor queue; its
//   words then go through the single output word register, one per cycle
//   while hdr_o.ready is high, until the last word; back-to-back requests
//   follow with no gap. The descriptor queue holds FifoDepth requests, so
//   requests are taken while an earlier header is still going out.
// Reset:
//   Clears the queue, the output valid and the own address registers.
// Stall:
//   When hdr_o.ready is low the current word holds; once the queue fills,
//   req_i.ready drops until the back end frees an entry.
module udp_arp_frame_header_generator_unit import uahg_pkg::*; #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  uahg_req_if.sink              req_i,
  uahg_hdr_if.source            hdr_o
);

  logic      push, pop, q_full, q_empty;
  req_desc_t wr_desc, rd_desc;
  own_cfg_t  own_cfg;

  uahg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .desc_o      (wr_desc),
    .cfg_o       (own_cfg)
  );

  uahg_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_desc),
    .pop_i   (pop),
    .rdata_o (rd_desc),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  uahg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .desc_i    (rd_desc),
    .q_empty_i (q_empty),
    .cfg_i     (own_cfg),
    .pop_o     (pop),
    .hdr_o     (hdr_o)
  );

endmodule

// ===== rtl/uahg_front.sv =====
// front end: configuration registers, request acceptance and descriptor build
module uahg_front import uahg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  uahg_req_if.sink              req_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output req_desc_t             desc_o,
  output own_cfg_t              cfg_o
);

  own_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_MAC:  cfg_d.own_mac  = cfg_wdata_i[MAC_W-1:0];
        CFG_OWN_IP:   cfg_d.own_ip   = cfg_wdata_i[IP_W-1:0];
        CFG_OWN_PORT: cfg_d.own_port = cfg_wdata_i[PORT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic [WORD_W-1:0] ip_len;
  logic [WORD_W-1:0] udp_len;

  assign ip_len  = req_i.payload_len + IP_LEN_ADD;
  assign udp_len = req_i.payload_len + UDP_LEN_ADD;

  assign req_i.ready = ~q_full_i;
  assign push_o      = req_i.valid & ~q_full_i;

  always_comb begin
    desc_o.func      = req_i.func;
    desc_o.peer_mac  = req_i.peer_mac;
    desc_o.peer_ip   = req_i.peer_ip;
    desc_o.peer_port = req_i.peer_port;
    desc_o.ip_len    = ip_len;
    desc_o.udp_len   = udp_len;
    // raw ipv4 header sum, folded later when the checksum word goes out
    desc_o.csum_sum  = SUM_W'(IP_VER_IHL) + SUM_W'(IP_TTL_PROTO) + SUM_W'(ip_len)
                     + SUM_W'(cfg_q.own_ip[31:16]) + SUM_W'(cfg_q.own_ip[15:0])
                     + SUM_W'(req_i.peer_ip[31:16]) + SUM_W'(req_i.peer_ip[15:0]);
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/uahg_fifo.sv =====
// short descriptor queue between front and back end
module uahg_fifo import uahg_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  req_desc_t wdata_i,
  input  logic      pop_i,
  output req_desc_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  req_desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/uahg_back.sv =====
// back end: walks the queued request word by word into the output register
module uahg_back import uahg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_desc_t desc_i,
  input  logic      q_empty_i,
  input  own_cfg_t  cfg_i,
  output logic      pop_o,
  uahg_hdr_if.source hdr_o
);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_last_q;
  logic              load;
  logic              last;

  // a request is queued and the output slot is free or being drained this cycle
  assign load  = ~q_empty_i & (~out_valid_q | hdr_o.ready);
  assign last  = is_last_pos(desc_i.func, pos_q);
  assign pop_o = load & last;

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (load) begin
      pos_d       = last ? '0 : pos_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (hdr_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= hdr_word_f(desc_i, cfg_i, pos_q);
      out_pos_q  <= pos_q;
      out_last_q <= last;
    end
  end

  assign hdr_o.valid    = out_valid_q;
  assign hdr_o.hdr_word = out_word_q;
  assign hdr_o.word_pos = out_pos_q;
  assign hdr_o.is_last  = out_last_q;

endmodule
